[rtl/line_edit_discipline_with_echo_core_defines.svh]
// Assertion macros shared by the line editor modules.
`ifndef LINE_EDIT_DISCIPLINE_WITH_ECHO_CORE_DEFINES_SVH
`define LINE_EDIT_DISCIPLINE_WITH_ECHO_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define LEDE_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the same edge.
`define LEDE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define LEDE_ASSERT(name, prop, msg)
`define LEDE_ASSERT_IMP(name, ante, cons, msg)

`endif

`endif

[rtl/lede_pkg.sv]
// Shared types, constants and echo functions of the line editor.
package lede_pkg;

    localparam int LINE_SIZE = 32;
    localparam int LINE_AW   = $clog2(LINE_SIZE);
    localparam int QDEPTH    = 2;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int CFG_IW    = 2;

    localparam logic [7:0] ASCII_BS = 8'h08;
    localparam logic [7:0] ASCII_SP = 8'h20;
    localparam logic [7:0] ASCII_CR = 8'h0D;
    localparam logic [7:0] ASCII_LF = 8'h0A;
    localparam logic [7:0] ASCII_NUL = 8'h00;

    localparam logic [7:0] ERASE_RESET  = 8'd127;
    localparam logic [7:0] RETURN_RESET = 8'd13;
    localparam logic [7:0] LIMIT_RESET  = 8'd255;

    localparam logic [CFG_IW-1:0] REG_ERASE  = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] REG_RETURN = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] REG_LIMIT  = CFG_IW'(2);

    typedef enum logic [1:0] {
        OP_CHAR   = 2'd0,
        OP_ERASE  = 2'd1,
        OP_RETURN = 2'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] code;
    } cmd_t;

    // Number of echo bytes an item produces.
    function automatic logic [1:0] echo_len(op_t op);
        logic [1:0] n;
        unique case (op)
            OP_ERASE:  n = 2'd3;
            OP_RETURN: n = 2'd2;
            default:   n = 2'd1;
        endcase
        return n;
    endfunction

    // Echo byte at position idx of an item's echo sequence.
    function automatic logic [7:0] echo_byte(op_t op, logic [7:0] code, logic [1:0] idx);
        logic [7:0] b;
        unique case (op)
            OP_ERASE:  b = (idx == 2'd1) ? ASCII_SP : ASCII_BS;
            OP_RETURN: b = (idx == 2'd0) ? ASCII_CR : ASCII_LF;
            default:   b = code;
        endcase
        return b;
    endfunction

endpackage

[rtl/lede_front.sv]
// Front end: configuration registers, input acceptance and byte classification.
module lede_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lede_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    rx_byte,
    output logic                          q_push,
    output lede_pkg::cmd_t                q_cmd,
    input  logic                          q_full,
    output logic [7:0]                    read_limit
);
    import lede_pkg::*;

    logic [7:0] erase_code_reg;
    logic [7:0] return_code_reg;
    logic [7:0] read_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erase_code_reg  <= ERASE_RESET;
            return_code_reg <= RETURN_RESET;
            read_limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ERASE:  erase_code_reg  <= cfg_data;
                REG_RETURN: return_code_reg <= cfg_data;
                REG_LIMIT:  read_limit_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Erase wins when both codes match.
    always_comb
    begin
        q_cmd.code = rx_byte;
        if (rx_byte == erase_code_reg)
            q_cmd.op = OP_ERASE;
        else if (rx_byte == return_code_reg)
            q_cmd.op = OP_RETURN;
        else
            q_cmd.op = OP_CHAR;
    end

    assign in_stall   = q_full;
    assign q_push     = in_valid && !q_full;
    assign read_limit = read_limit_reg;

endmodule

[rtl/lede_queue.sv]
// Short command queue between the front end and the back end.
`include "line_edit_discipline_with_echo_core_defines.svh"

module lede_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lede_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output lede_pkg::cmd_t  pop_cmd
);
    import lede_pkg::*;

    cmd_t           slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic           do_push;
    logic           do_pop;

    assign full      = count_reg == (QAW+1)'(QDEPTH);
    assign pop_valid = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `LEDE_ASSERT(a_count_range, count_reg <= (QAW+1)'(QDEPTH), "queue count over depth")
    `LEDE_ASSERT_IMP(a_empty_ptrs, count_reg == '0, wr_ptr_reg == rd_ptr_reg, "empty queue pointers differ")
    `LEDE_ASSERT_IMP(a_pop_moves, do_pop && !do_push, count_reg != '0, "pop from empty queue")

endmodule

[rtl/lede_back.sv]
// Back end: line store, cursor, echo sequencing and line delivery.
`include "line_edit_discipline_with_echo_core_defines.svh"

module lede_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  lede_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    input  logic [7:0]      read_limit,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            kind,
    output logic [7:0]      data,
    output logic            last
);
    import lede_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ECHO = 4'b0010,
        ST_RD   = 4'b0100,
        ST_LD   = 4'b1000
    } state_t;

    localparam logic [LINE_AW-1:0] LAST_POS = LINE_AW'(LINE_SIZE - 1);

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [1:0]         echo_idx_reg, echo_idx_next;
    logic [LINE_AW-1:0] line_cnt_reg, line_cnt_next;
    logic [LINE_AW-1:0] rd_idx_reg, rd_idx_next;
    logic [LINE_AW-1:0] cursor_reg, cursor_next;
    logic [7:0]         rdata_reg;
    logic [7:0]         line_mem [LINE_SIZE];

    logic               out_valid_reg, out_valid_next;
    logic               kind_reg;
    logic [7:0]         data_reg;
    logic               last_reg;

    logic               out_free;
    logic               out_load;
    logic               load_kind;
    logic [7:0]         load_data;
    logic               load_last;
    logic               mem_we;
    logic [7:0]         mem_wdata;
    logic               room;
    logic               line_done;
    logic [LINE_AW-1:0] line_len;
    logic               echo_last;

    assign out_free  = !out_valid_reg || !out_stall;
    assign room      = cursor_reg != LAST_POS;
    assign echo_last = echo_idx_reg == (echo_len(cmd_reg.op) - 2'd1);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        echo_idx_next = echo_idx_reg;
        line_cnt_next = line_cnt_reg;
        rd_idx_next   = rd_idx_reg;
        cursor_next   = cursor_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_wdata     = q_cmd.code;
        line_done     = 1'b0;
        line_len      = cursor_reg;
        out_load      = 1'b0;
        load_kind     = 1'b0;
        load_data     = echo_byte(cmd_reg.op, cmd_reg.code, echo_idx_reg);
        load_last     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    cmd_next      = q_cmd;
                    echo_idx_next = 2'd0;
                    line_cnt_next = '0;
                    state_next    = ST_ECHO;
                    unique case (q_cmd.op)
                        OP_ERASE:
                        begin
                            if (cursor_reg != '0)
                                cursor_next = cursor_reg - 1'b1;
                        end
                        OP_RETURN:
                        begin
                            line_done = 1'b1;
                            if (room)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = ASCII_LF;
                                line_len  = cursor_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            // Drop the byte when the line is full.
                            if (room)
                            begin
                                mem_we      = 1'b1;
                                line_len    = cursor_reg + 1'b1;
                                cursor_next = cursor_reg + 1'b1;
                                line_done   = q_cmd.code == ASCII_NUL;
                            end
                        end
                    endcase
                    if (line_done)
                    begin
                        cursor_next = '0;
                        if (9'(read_limit) < 9'(line_len))
                            line_cnt_next = LINE_AW'(read_limit);
                        else
                            line_cnt_next = line_len;
                    end
                end
            end
            ST_ECHO:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    load_last = echo_last && (line_cnt_reg == '0);
                    if (echo_last)
                    begin
                        rd_idx_next = '0;
                        state_next  = (line_cnt_reg == '0) ? ST_IDLE : ST_RD;
                    end
                    else
                    begin
                        echo_idx_next = echo_idx_reg + 2'd1;
                    end
                end
            end
            ST_RD:
            begin
                // Store read is under way; data lands in rdata_reg.
                state_next = ST_LD;
            end
            ST_LD:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    load_kind = 1'b1;
                    load_data = rdata_reg;
                    load_last = rd_idx_reg == (line_cnt_reg - 1'b1);
                    if (load_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[cursor_reg] <= mem_wdata;
        rdata_reg <= line_mem[rd_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            echo_idx_reg  <= 2'd0;
            line_cnt_reg  <= '0;
            rd_idx_reg    <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            echo_idx_reg  <= echo_idx_next;
            line_cnt_reg  <= line_cnt_next;
            rd_idx_reg    <= rd_idx_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (out_load)
        begin
            kind_reg <= load_kind;
            data_reg <= load_data;
            last_reg <= load_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign last      = last_reg;

    `LEDE_ASSERT_IMP(a_final_echo_no_line, out_valid_reg && !kind_reg && last_reg, state_reg != ST_RD && state_reg != ST_LD, "line delivery after final echo")
    `LEDE_ASSERT_IMP(a_cursor_cleared, state_reg == ST_RD || state_reg == ST_LD, cursor_reg == '0, "cursor not cleared during line delivery")
    `LEDE_ASSERT_IMP(a_rd_in_range, state_reg == ST_RD || state_reg == ST_LD, rd_idx_reg < line_cnt_reg, "line read index past count")

endmodule

[rtl/line_edit_discipline_with_echo_core.sv]
// Top level of the line editor with echo: front end, command queue, back end.
//
//  channel | direction | handshake             | payload
//  cfg     | in        | cfg_we                | cfg_index, cfg_data
//  in      | in        | in_valid / in_stall   | rx_byte
//  out     | out       | out_valid / out_stall | kind, data, last
//
// In the back end an item first edits the line store in ST_IDLE, then sends its
// echo bytes (1 to 3) one by one in ST_ECHO, then delivers each line byte through
// ST_RD and ST_LD, which wait on the registered read of the line store.
// The front end takes a new item whenever the two-entry queue has room.
// Reset restores the register defaults and empties the line; the store holds junk.
// A stalled result holds the back end; the front end keeps filling the queue.
module line_edit_discipline_with_echo_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [lede_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [7:0]                   cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   rx_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         kind,
    output logic [7:0]                   data,
    output logic                         last
);
    import lede_pkg::*;

    cmd_t       push_cmd;
    cmd_t       pop_cmd;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    logic [7:0] read_limit;

    lede_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .q_push     (q_push),
        .q_cmd      (push_cmd),
        .q_full     (q_full),
        .read_limit (read_limit)
    );

    lede_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (pop_cmd)
    );

    lede_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (pop_cmd),
        .q_pop      (q_pop),
        .read_limit (read_limit),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .data       (data),
        .last       (last)
    );

endmodule
